// ===== hw/rtl/pajm_pkg.sv =====
`timescale 1ns / 1ps

package pajm_pkg;

    localparam int TIME_W     = 32;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_W      = 64;
    localparam int DEV_W      = 56;
    localparam int RATE_W     = 26;
    localparam int JIT_W      = 24;
    localparam int GAP_W      = 16;
    localparam int LOSS_W     = 15;
    localparam int RSCALE_W   = 18;
    localparam int LSCALE_W   = 15;
    localparam int MISS_W     = 31;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL = 2'd1;

    localparam logic [CFG_W-1:0]    WINDOW_RESET = 16'd2000;
    localparam logic [RSCALE_W-1:0] RATE_SCALE   = 18'd256000;
    localparam logic [LSCALE_W-1:0] LOSS_SCALE   = 15'd25600;
    localparam logic [RATE_W-1:0]   RATE_MAX     = 26'h3FF_FFFF;
    localparam logic [JIT_W-1:0]    JIT_MAX      = 24'hFF_FFFF;
    localparam logic [GAP_W-1:0]    GAP_MAX      = 16'hFFFF;
    localparam logic [TIME_W-1:0]   SIGN_BIT     = 32'h8000_0000;

    typedef enum logic [1:0] {
        SCAN_COLLECT,
        SCAN_DEV,
        SCAN_SEL
    } t_scan;

    typedef enum logic [1:0] {
        DIV_RATE,
        DIV_JIT,
        DIV_LOSS
    } t_div_sel;

    typedef struct packed {
        logic     record;
        logic     capture;
        logic     rd_newest;
        logic     stale_cap;
        logic     scan_start;
        t_scan    scan_kind;
        logic     prep;
        logic     div_start;
        t_div_sel div_sel;
        logic     sel_update;
        logic     lm1;
        logic     lm2;
        logic     lm3;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic ok;
        logic div_done;
        logic sel_last;
        logic nom_cfg_zero;
        logic loss_go;
        logic out_free;
    } t_status;

endpackage

// ===== hw/rtl/pajm_ram.sv =====
`timescale 1ns / 1ps

module pajm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pajm_div.sv =====
`timescale 1ns / 1ps

module pajm_div #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic [W-1:0] o_quotient,
    output logic         o_done
);

    localparam int CNT_W = $clog2(W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_q;
    logic [W-1:0]     r_d;
    logic [W:0]       w_sh;
    logic [W+1:0]     w_diff;
    logic             w_ge;

    // Restoring division, one quotient bit per cycle.
    assign w_sh   = {r_rem, r_q[W-1]};
    assign w_diff = {1'b0, w_sh} - {2'b00, r_d};
    assign w_ge   = !w_diff[W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[W-1:0] : w_sh[W-1:0];
            r_q   <= {r_q[W-2:0], w_ge};
        end
    end

    assign o_quotient = r_q;
    assign o_done     = r_done;

endmodule

// ===== hw/rtl/pajm_ctrl.sv =====
`timescale 1ns / 1ps

module pajm_ctrl import pajm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_action,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_RD_NEWEST, ST_STALE, ST_COLLECT, ST_CHECK, ST_BRANCH,
        ST_DEV, ST_DEV_WAIT, ST_DIV_RATE, ST_WAIT_RATE, ST_DIV_JIT, ST_WAIT_JIT,
        ST_SEL_SCAN, ST_SEL_WAIT, ST_SEL_UPD, ST_LM1, ST_LM2, ST_LM3,
        ST_DIV_LOSS, ST_WAIT_LOSS, ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   w_cmd;

    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_action) begin
                        w_cmd.capture = 1'b1;
                        n_state       = ST_RD_NEWEST;
                    end else begin
                        w_cmd.record = 1'b1;
                    end
                end
            end
            ST_RD_NEWEST: begin
                w_cmd.rd_newest = 1'b1;
                n_state         = ST_STALE;
            end
            ST_STALE: begin
                w_cmd.stale_cap  = 1'b1;
                w_cmd.scan_start = 1'b1;
                w_cmd.scan_kind  = SCAN_COLLECT;
                n_state          = ST_COLLECT;
            end
            ST_COLLECT: begin
                if (i_status.scan_done) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                w_cmd.prep = 1'b1;
                n_state    = ST_BRANCH;
            end
            ST_BRANCH: begin
                n_state = i_status.ok ? ST_DEV : ST_FINISH;
            end
            ST_DEV: begin
                w_cmd.scan_start = 1'b1;
                w_cmd.scan_kind  = SCAN_DEV;
                n_state          = ST_DEV_WAIT;
            end
            ST_DEV_WAIT: begin
                if (i_status.scan_done) begin
                    n_state = ST_DIV_RATE;
                end
            end
            ST_DIV_RATE: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DIV_RATE;
                n_state         = ST_WAIT_RATE;
            end
            ST_WAIT_RATE: begin
                if (i_status.div_done) begin
                    n_state = ST_DIV_JIT;
                end
            end
            ST_DIV_JIT: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DIV_JIT;
                n_state         = ST_WAIT_JIT;
            end
            ST_WAIT_JIT: begin
                if (i_status.div_done) begin
                    n_state = i_status.nom_cfg_zero ? ST_SEL_SCAN : ST_LM1;
                end
            end
            ST_SEL_SCAN: begin
                w_cmd.scan_start = 1'b1;
                w_cmd.scan_kind  = SCAN_SEL;
                n_state          = ST_SEL_WAIT;
            end
            ST_SEL_WAIT: begin
                if (i_status.scan_done) begin
                    n_state = ST_SEL_UPD;
                end
            end
            ST_SEL_UPD: begin
                w_cmd.sel_update = 1'b1;
                n_state          = i_status.sel_last ? ST_LM1 : ST_SEL_SCAN;
            end
            ST_LM1: begin
                w_cmd.lm1 = 1'b1;
                n_state   = ST_LM2;
            end
            ST_LM2: begin
                w_cmd.lm2 = 1'b1;
                n_state   = ST_LM3;
            end
            ST_LM3: begin
                w_cmd.lm3 = 1'b1;
                n_state   = i_status.loss_go ? ST_DIV_LOSS : ST_FINISH;
            end
            ST_DIV_LOSS: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DIV_LOSS;
                n_state         = ST_WAIT_LOSS;
            end
            ST_WAIT_LOSS: begin
                if (i_status.div_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = w_cmd;
    assign o_in_stall = (r_state != ST_IDLE);

endmodule

// ===== hw/rtl/pajm_dp.sv =====
`timescale 1ns / 1ps

module pajm_dp import pajm_pkg::*; #(
    parameter int RING_DEPTH = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic [TIME_W-1:0]    i_time_ms,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic                 o_stats_valid,
    output logic [RATE_W-1:0]    o_rate_q8,
    output logic [JIT_W-1:0]     o_jitter_q8,
    output logic [GAP_W-1:0]     o_max_gap_ms,
    output logic [LOSS_W-1:0]    o_loss_q8,
    output logic signed [TIME_W-1:0] o_stale_ms
);

    localparam int AW   = $clog2(RING_DEPTH);
    localparam int CW   = $clog2(RING_DEPTH + 1);
    localparam int MW   = TIME_W + CW + 1;
    localparam int LNW  = MISS_W + LSCALE_W;
    localparam int RNW  = CW + RSCALE_W;

    // Configuration.
    logic [CFG_W-1:0] r_window;
    logic [CFG_W-1:0] r_nominal;

    // Ring bookkeeping.
    logic [AW-1:0]     r_wp;
    logic [CW-1:0]     r_count;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_stale;

    // Scan engine.
    t_scan         r_kind;
    logic          r_active;
    logic [AW-1:0] r_addr;
    logic [CW-1:0] r_left;
    logic          r_p1;
    logic          r_p2;
    logic          w_scan_done;

    // Collection.
    logic [CW-1:0]     r_n;
    logic [TIME_W-1:0] r_first;
    logic [TIME_W-1:0] r_prev;

    // Statistics.
    logic                   r_ok;
    logic [CW-1:0]          r_g;
    logic [TIME_W-1:0]      r_span;
    logic [2*CW-1:0]        r_d2;
    logic [RNW-1:0]         r_rate_num;
    logic signed [MW-1:0]   r_mul;
    logic [TIME_W-1:0]      r_gap2;
    logic [DEV_W-1:0]       r_dev;
    logic signed [TIME_W-1:0] r_maxg;

    // Median selection.
    logic [TIME_W-1:0] r_prefix;
    logic [TIME_W-1:0] r_mask;
    logic [TIME_W-1:0] r_bit;
    logic [CW-1:0]     r_k;
    logic [CW-1:0]     r_cnt;

    // Loss.
    logic signed [MW-1:0] r_prod;
    logic                 r_nom_pos;
    logic [MISS_W-1:0]    r_miss;
    logic                 r_miss_pos;
    logic [LNW-1:0]       r_loss_num;

    // Results.
    logic [RATE_W-1:0] r_rate;
    logic [JIT_W-1:0]  r_jit;
    logic [LOSS_W-1:0] r_loss;
    t_div_sel          r_dsel;

    // Output register.
    logic              r_out_valid;
    logic              r_o_ok;
    logic [RATE_W-1:0] r_o_rate;
    logic [JIT_W-1:0]  r_o_jit;
    logic [GAP_W-1:0]  r_o_gap;
    logic [LOSS_W-1:0] r_o_loss;
    logic [TIME_W-1:0] r_o_stale;

    // Memories and divider.
    logic [AW-1:0]     w_ring_raddr;
    logic [TIME_W-1:0] w_ring_rdata;
    logic              w_gap_we;
    logic [TIME_W-1:0] w_gap_wdata;
    logic [TIME_W-1:0] w_gap_rdata;
    logic [CW-1:0]     w_nm1;
    logic [DIV_W-1:0]  w_dividend;
    logic [DIV_W-1:0]  w_divisor;
    logic [DIV_W-1:0]  w_quot;
    logic              w_div_done;

    logic [AW-1:0]     w_newest;
    logic [AW-1:0]     w_oldest;
    logic [AW-1:0]     w_addr_inc;
    logic [TIME_W-1:0] w_age;
    logic              w_keep;
    logic [CW-1:0]     w_g;
    logic [TIME_W-1:0] w_span;
    logic signed [MW:0] w_e;
    logic [MW:0]       w_abs;
    logic [TIME_W-1:0] w_key;
    logic              w_match;
    logic signed [TIME_W-1:0] w_nom;
    logic signed [MW:0] w_miss;

    assign w_newest   = (r_wp == '0) ? AW'(RING_DEPTH - 1) : r_wp - 1'b1;
    assign w_oldest   = (r_count == CW'(RING_DEPTH)) ? r_wp : '0;
    assign w_addr_inc = (r_addr == AW'(RING_DEPTH - 1)) ? '0 : r_addr + 1'b1;
    assign w_ring_raddr = i_cmd.rd_newest ? w_newest : r_addr;

    assign w_age  = r_now - w_ring_rdata;
    assign w_keep = !($signed(w_age) > $signed({16'h0000, r_window}));
    assign w_nm1  = r_n - 1'b1;
    assign w_gap_we    = r_p1 && (r_kind == SCAN_COLLECT) && w_keep && (r_n != '0);
    assign w_gap_wdata = w_ring_rdata - r_prev;

    assign w_g    = r_n - 1'b1;
    assign w_span = r_prev - r_first;

    assign w_e   = $signed({r_mul[MW-1], r_mul})
                 - $signed({{(MW + 1 - TIME_W){r_span[TIME_W-1]}}, r_span});
    assign w_abs = w_e[MW] ? (~w_e + 1'b1) : w_e;

    assign w_key   = w_gap_rdata ^ SIGN_BIT;
    assign w_match = (((w_key ^ r_prefix) & r_mask) == '0) && ((w_key & r_bit) == '0);

    assign w_nom  = (r_nominal != '0) ? $signed({16'h0000, r_nominal})
                                      : $signed(r_prefix ^ SIGN_BIT);
    assign w_miss = $signed({{(MW + 1 - TIME_W){r_span[TIME_W-1]}}, r_span})
                  - $signed({r_prod[MW-1], r_prod});

    assign w_scan_done = r_active && (r_left == '0) && !r_p1 && !r_p2;

    always_comb begin
        w_dividend = '0;
        w_divisor  = DIV_W'(r_span);
        case (i_cmd.div_sel)
            DIV_RATE: w_dividend = DIV_W'(r_rate_num);
            DIV_JIT: begin
                w_dividend = {r_dev, 8'h00};
                w_divisor  = DIV_W'(r_d2);
            end
            DIV_LOSS: w_dividend = DIV_W'(r_loss_num);
            default: w_dividend = '0;
        endcase
    end

    pajm_ram #(.WIDTH(TIME_W), .DEPTH(RING_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.record),
        .i_waddr (r_wp),
        .i_wdata (i_time_ms),
        .i_raddr (w_ring_raddr),
        .o_rdata (w_ring_rdata)
    );

    pajm_ram #(.WIDTH(TIME_W), .DEPTH(RING_DEPTH)) u_gaps (
        .i_clk   (i_clk),
        .i_we    (w_gap_we),
        .i_waddr (w_nm1[AW-1:0]),
        .i_wdata (w_gap_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_gap_rdata)
    );

    pajm_div #(.W(DIV_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quot),
        .o_done     (w_div_done)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RESET;
            r_nominal   <= '0;
            r_wp        <= '0;
            r_count     <= '0;
            r_active    <= 1'b0;
            r_left      <= '0;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_WINDOW) begin
                    r_window <= i_cfg_data;
                end else if (i_cfg_index == REG_NOMINAL) begin
                    r_nominal <= i_cfg_data;
                end
            end
            if (i_cmd.record) begin
                r_wp <= (r_wp == AW'(RING_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                if (r_count != CW'(RING_DEPTH)) begin
                    r_count <= r_count + 1'b1;
                end
            end
            r_p1 <= r_active && (r_left != '0);
            r_p2 <= r_p1;
            if (i_cmd.scan_start) begin
                r_active <= 1'b1;
                r_left   <= (i_cmd.scan_kind == SCAN_COLLECT) ? r_count : r_g;
            end else begin
                if (r_left != '0) begin
                    r_left <= r_left - 1'b1;
                end
                if (w_scan_done) begin
                    r_active <= 1'b0;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now <= i_time_ms;
        end
        if (i_cmd.stale_cap) begin
            r_stale <= (r_count != '0) ? r_now - w_ring_rdata : '0;
        end

        if (i_cmd.scan_start) begin
            r_kind <= i_cmd.scan_kind;
            r_cnt  <= '0;
            if (i_cmd.scan_kind == SCAN_COLLECT) begin
                r_addr <= w_oldest;
                r_n    <= '0;
            end else begin
                r_addr <= '0;
            end
        end else if (r_left != '0) begin
            r_addr <= w_addr_inc;
        end

        if (r_p1) begin
            case (r_kind)
                SCAN_COLLECT: begin
                    if (w_keep) begin
                        if (r_n == '0) begin
                            r_first <= w_ring_rdata;
                        end
                        r_prev <= w_ring_rdata;
                        r_n    <= r_n + 1'b1;
                    end
                end
                SCAN_DEV: begin
                    r_mul  <= $signed(w_gap_rdata) * $signed({1'b0, r_g});
                    r_gap2 <= w_gap_rdata;
                end
                SCAN_SEL: begin
                    if (w_match) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end

        if (r_p2 && (r_kind == SCAN_DEV)) begin
            r_dev <= r_dev + DEV_W'(w_abs);
            if ($signed(r_gap2) > r_maxg) begin
                r_maxg <= $signed(r_gap2);
            end
        end

        if (i_cmd.prep) begin
            r_g        <= w_g;
            r_span     <= w_span;
            r_ok       <= (r_n >= CW'(3)) && ($signed(w_span) > 0);
            r_d2       <= w_g * w_g;
            r_rate_num <= w_g * RATE_SCALE;
            r_dev      <= '0;
            r_maxg     <= '0;
            r_prefix   <= '0;
            r_mask     <= '0;
            r_bit      <= SIGN_BIT;
            r_k        <= w_g >> 1;
            r_rate     <= '0;
            r_jit      <= '0;
            r_loss     <= '0;
        end

        if (i_cmd.sel_update) begin
            if (r_k >= r_cnt) begin
                r_prefix <= r_prefix | r_bit;
                r_k      <= r_k - r_cnt;
            end
            r_mask <= r_mask | r_bit;
            r_bit  <= r_bit >> 1;
        end

        if (i_cmd.lm1) begin
            r_prod    <= w_nom * $signed({1'b0, r_g});
            r_nom_pos <= (w_nom > 0);
        end
        if (i_cmd.lm2) begin
            r_miss_pos <= r_nom_pos && !w_miss[MW] && (w_miss != '0);
            r_miss     <= w_miss[MISS_W-1:0];
        end
        if (i_cmd.lm3) begin
            r_loss_num <= r_miss * LOSS_SCALE;
        end

        if (i_cmd.div_start) begin
            r_dsel <= i_cmd.div_sel;
        end
        if (w_div_done) begin
            case (r_dsel)
                DIV_RATE: r_rate <= (w_quot > DIV_W'(RATE_MAX)) ? RATE_MAX
                                                                : w_quot[RATE_W-1:0];
                DIV_JIT:  r_jit  <= (w_quot > DIV_W'(JIT_MAX)) ? JIT_MAX
                                                               : w_quot[JIT_W-1:0];
                DIV_LOSS: r_loss <= w_quot[LOSS_W-1:0];
                default:  r_loss <= r_loss;
            endcase
        end

        if (i_cmd.out_load) begin
            r_o_ok    <= r_ok;
            r_o_rate  <= r_ok ? r_rate : '0;
            r_o_jit   <= r_ok ? r_jit : '0;
            r_o_loss  <= r_ok ? r_loss : '0;
            r_o_stale <= r_stale;
            if (!r_ok) begin
                r_o_gap <= '0;
            end else if (r_maxg > $signed({16'h0000, GAP_MAX})) begin
                r_o_gap <= GAP_MAX;
            end else begin
                r_o_gap <= r_maxg[GAP_W-1:0];
            end
        end
    end

    assign o_status.scan_done    = w_scan_done;
    assign o_status.ok           = r_ok;
    assign o_status.div_done     = w_div_done;
    assign o_status.sel_last     = r_bit[0];
    assign o_status.nom_cfg_zero = (r_nominal == '0);
    assign o_status.loss_go      = r_miss_pos;
    assign o_status.out_free     = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_stats_valid = r_o_ok;
    assign o_rate_q8     = r_o_rate;
    assign o_jitter_q8   = r_o_jit;
    assign o_max_gap_ms  = r_o_gap;
    assign o_loss_q8     = r_o_loss;
    assign o_stale_ms    = $signed(r_o_stale);

endmodule

// ===== hw/rtl/packet_arrival_jitter_meter.sv =====
`timescale 1ns / 1ps
// Flow: a record beat gives no result. A measure beat yields its result after the
// ring walk, the gap walk, the divisions for rate and jitter, then, when no nominal
// interval is set, 32 median passes over the gaps, and a division for loss when loss
// is found; a nonzero nominal interval skips the passes. Throughput: one measure at a
// time; records every cycle while no measure is in progress.
// Reset: synchronous, active low; clears pointers, counts and handshakes, and restores the config defaults.

module packet_arrival_jitter_meter import pajm_pkg::*; #(
    parameter int RING_DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_action,
    input  logic [TIME_W-1:0]        i_time_ms,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_stats_valid,
    output logic [RATE_W-1:0]        o_rate_q8,
    output logic [JIT_W-1:0]         o_jitter_q8,
    output logic [GAP_W-1:0]         o_max_gap_ms,
    output logic [LOSS_W-1:0]        o_loss_q8,
    output logic signed [TIME_W-1:0] o_stale_ms
);

    // The controller sequences a measurement: it reads the newest arrival for
    // staleness, walks the ring oldest first to collect in-window gaps, walks
    // the gaps for deviation and largest gap, then runs the shared divider for
    // rate and jitter. When no nominal interval is set, it runs one pass over
    // the gaps per key bit to select the upper median; in either case it then computes loss.
    t_cmd    w_cmd;
    t_status w_status;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    pajm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the ring and gap memories, the scan engine, the
    // accumulators and the output register, which frees the controller to take
    // new beats while a finished result waits.
    pajm_dp #(.RING_DEPTH(RING_DEPTH)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_time_ms     (i_time_ms),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_stats_valid (o_stats_valid),
        .o_rate_q8     (o_rate_q8),
        .o_jitter_q8   (o_jitter_q8),
        .o_max_gap_ms  (o_max_gap_ms),
        .o_loss_q8     (o_loss_q8),
        .o_stale_ms    (o_stale_ms)
    );

    // A measure beat must hold off further input on the next cycle.
    a_measure_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_action) |=> o_in_stall)
        else $error("measure beat did not make the block busy");

    // Without valid statistics every figure except staleness reads zero.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_stats_valid) |->
        (o_rate_q8 == '0 && o_jitter_q8 == '0 && o_max_gap_ms == '0 && o_loss_q8 == '0))
        else $error("invalid result carries nonzero statistics");

    // Loss never exceeds one hundred percent.
    a_loss_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_loss_q8 <= 15'd25600))
        else $error("loss above one hundred percent");

endmodule

// ===== tb/jitter_checker.sv =====
`timescale 1ns / 1ps

module jitter_checker import pajm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic                     i_action,
    input  logic [TIME_W-1:0]        i_time_ms,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic                     i_stats_valid,
    input  logic [RATE_W-1:0]        i_rate_q8,
    input  logic [JIT_W-1:0]         i_jitter_q8,
    input  logic [GAP_W-1:0]         i_max_gap_ms,
    input  logic [LOSS_W-1:0]        i_loss_q8,
    input  logic signed [TIME_W-1:0] i_stale_ms,
    output int                       o_errors,
    output int                       o_pending,
    output int                       o_measured
);

    localparam int DEPTH = 256;

    typedef struct {
        logic              stats_valid;
        logic [RATE_W-1:0] rate;
        logic [JIT_W-1:0]  jitter;
        logic [GAP_W-1:0]  max_gap;
        logic [LOSS_W-1:0] loss;
        logic [TIME_W-1:0] stale;
    } jitter_stats_t;

    logic [TIME_W-1:0] arrivals [DEPTH];
    logic [7:0]        head;
    int                filled;
    logic [CFG_W-1:0]  age_limit;
    logic [CFG_W-1:0]  expect_gap;
    jitter_stats_t     stats_q [$];

    function automatic longint wrap_diff(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return longint'($signed(d));
    endfunction

    function automatic jitter_stats_t measure_window(logic [TIME_W-1:0] now);
        jitter_stats_t     s;
        longint            gaps [DEPTH];
        longint            span, maxg, nom, miss, e, v;
        longint unsigned   dev, d2, q, r, rate, jit;
        logic [TIME_W-1:0] first, prev, t;
        int                n, g, j;
        s = '{default: '0};
        n = 0;
        first = '0;
        prev = '0;
        if (filled > 0)
            s.stale = now - arrivals[(int'(head) + DEPTH - 1) % DEPTH];
        for (int i = 0; i < filled; i++) begin
            t = arrivals[(int'(head) + DEPTH + i - filled) % DEPTH];
            if (wrap_diff(now, t) > longint'(age_limit))
                continue;
            if (n > 0)
                gaps[n-1] = wrap_diff(t, prev);
            else
                first = t;
            prev = t;
            n++;
        end
        if (n < 3)
            return s;
        g = n - 1;
        span = wrap_diff(prev, first);
        if (span <= 0)
            return s;
        dev = 0;
        maxg = 0;
        for (int i = 0; i < g; i++) begin
            e = gaps[i] * g - span;
            dev += longint'(e < 0 ? -e : e);
            if (gaps[i] > maxg)
                maxg = gaps[i];
        end
        rate = (64'd256000 * g) / span;
        if (rate > RATE_MAX)
            rate = RATE_MAX;
        d2 = g * g;
        q = dev / d2;
        r = dev % d2;
        jit = (q >= 65536) ? JIT_MAX : q * 256 + (r * 256) / d2;
        if (jit > JIT_MAX)
            jit = JIT_MAX;
        if (maxg > 65535)
            maxg = 65535;
        nom = expect_gap;
        if (nom == 0) begin
            // Upper median of the gaps, taken from an ascending sort.
            for (int i = 1; i < g; i++) begin
                v = gaps[i];
                j = i;
                while (j > 0 && gaps[j-1] > v) begin
                    gaps[j] = gaps[j-1];
                    j--;
                end
                gaps[j] = v;
            end
            nom = gaps[g / 2];
        end
        if (nom > 0) begin
            miss = span - g * nom;
            if (miss > 0)
                s.loss = LOSS_W'((miss * 25600) / span);
        end
        s.stats_valid = 1'b1;
        s.rate = RATE_W'(rate);
        s.jitter = JIT_W'(jit);
        s.max_gap = GAP_W'(maxg);
        return s;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            o_errors++;
        end
    endfunction

    assign o_pending = stats_q.size();

    initial begin
        o_errors = 0;
        o_measured = 0;
    end

    always @(posedge i_clk) begin
        jitter_stats_t want;
        if (!i_rst_n) begin
            head <= '0;
            filled <= 0;
            age_limit <= WINDOW_RESET;
            expect_gap <= '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_WINDOW)
                    age_limit <= i_cfg_data;
                else if (i_cfg_index == REG_NOMINAL)
                    expect_gap <= i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_action) begin
                    stats_q.push_back(measure_window(i_time_ms));
                end else begin
                    arrivals[head] <= i_time_ms;
                    head <= head + 8'd1;
                    if (filled < DEPTH)
                        filled <= filled + 1;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (stats_q.size() == 0) begin
                    $error("result beat with no measurement outstanding");
                    o_errors++;
                end else begin
                    want = stats_q.pop_front();
                    o_measured++;
                    check_field("stats_valid", want.stats_valid, i_stats_valid);
                    check_field("rate_q8", want.rate, i_rate_q8);
                    check_field("jitter_q8", want.jitter, i_jitter_q8);
                    check_field("max_gap_ms", want.max_gap, i_max_gap_ms);
                    check_field("loss_q8", want.loss, i_loss_q8);
                    check_field("stale_ms", want.stale, $unsigned(i_stale_ms));
                end
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import pajm_pkg::*;

    // Action codes carried on the input channel.
    localparam logic ACT_RECORD  = 1'b0;
    localparam logic ACT_MEASURE = 1'b1;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic                     i_action;
    logic [TIME_W-1:0]        i_time_ms;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_W-1:0]         i_cfg_data;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic                     o_stats_valid;
    logic [RATE_W-1:0]        o_rate_q8;
    logic [JIT_W-1:0]         o_jitter_q8;
    logic [GAP_W-1:0]         o_max_gap_ms;
    logic [LOSS_W-1:0]        o_loss_q8;
    logic signed [TIME_W-1:0] o_stale_ms;

    int                error_count;
    int                pending_count;
    int                measured_count;
    int                record_count;
    bit                quiet;
    logic [TIME_W-1:0] last_arrival;

    // 4 ns clock: 2 ns high, 2 ns low.
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    packet_arrival_jitter_meter u_top (.*);

    jitter_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_time_ms    (i_time_ms),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_stats_valid(o_stats_valid),
        .i_rate_q8    (o_rate_q8),
        .i_jitter_q8  (o_jitter_q8),
        .i_max_gap_ms (o_max_gap_ms),
        .i_loss_q8    (o_loss_q8),
        .i_stale_ms   (o_stale_ms),
        .o_errors     (error_count),
        .o_pending    (pending_count),
        .o_measured   (measured_count)
    );

    // Hard stop in case the block hangs, with a wide margin over the slowest
    // legal run.
    initial begin
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // The result side stalls in random bursts until the quiet tail of the run.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
        end
    end

    // Presents one beat and returns at the edge where it is taken. Valid stays
    // high between back-to-back beats, so it is only lowered for an idle burst.
    task automatic send_beat(logic act, logic [TIME_W-1:0] stamp);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_time_ms <= stamp;
        do @(posedge i_clk); while (o_in_stall);
        if (act == ACT_RECORD)
            record_count++;
    endtask

    task automatic record_at(logic [TIME_W-1:0] stamp);
        send_beat(ACT_RECORD, stamp);
        last_arrival = stamp;
    endtask

    // Lets every outstanding measurement drain, then idles on so that a record
    // still in flight has landed before the registers move.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [CFG_W-1:0] window, logic [CFG_W-1:0] nominal);
        drain();
        write_reg(REG_WINDOW, window);
        write_reg(REG_NOMINAL, nominal);
    endtask

    // One random phase. Arrivals mostly follow a steady cadence with jitter;
    // some repeat, some go backwards, some jump far ahead, and a few are pure
    // noise anywhere in the 32-bit range. Measurements land just after the
    // newest arrival, now and then slightly before it.
    task automatic random_phase(int beats, logic [TIME_W-1:0] base, bit pause_once);
        int pick;
        last_arrival = base;
        for (int k = 0; k < beats; k++) begin
            if (pause_once && k == beats / 2) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                while (pending_count != 0) @(negedge i_clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                if ($urandom_range(0, 9) == 0)
                    send_beat(ACT_MEASURE, last_arrival - $urandom_range(1, 30));
                else
                    send_beat(ACT_MEASURE, last_arrival + $urandom_range(0, 40));
            end else if (pick < 25) begin
                record_at($urandom());
            end else if (pick < 32) begin
                record_at(last_arrival);
            end else if (pick < 37) begin
                record_at(last_arrival - $urandom_range(1, 30));
            end else if (pick < 42) begin
                record_at(last_arrival + $urandom_range(300, 3000));
            end else begin
                record_at(last_arrival + $urandom_range(12, 28));
            end
        end
    endtask

    initial begin
        quiet = 1'b0;
        record_count = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_action = ACT_RECORD;
        i_time_ms = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_WINDOW;
        i_cfg_data = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, under the reset settings first. An empty ring reports
        // zero staleness, and too few arrivals leave the statistics at zero.
        send_beat(ACT_MEASURE, 32'd1000);
        record_at(32'd1000);
        send_beat(ACT_MEASURE, 32'd1005);
        // Three arrivals with the same stamp: enough gaps but no span.
        record_at(32'd1000);
        record_at(32'd1000);
        send_beat(ACT_MEASURE, 32'd1001);
        // Out-of-order arrival gives a negative gap; then a measurement taken
        // before the newest arrival gives negative staleness.
        record_at(32'd1020);
        record_at(32'd1045);
        record_at(32'd1030);
        send_beat(ACT_MEASURE, 32'd1050);
        record_at(32'd1070);
        send_beat(ACT_MEASURE, 32'd1060);

        // A window of 1 ms and the widest nominal interval.
        configure(16'd1, 16'hFFFF);
        record_at(32'd1071);
        record_at(32'd1071);
        send_beat(ACT_MEASURE, 32'd1071);
        send_beat(ACT_MEASURE, 32'd1072);

        // Widest window with a small nominal interval; timestamps wrap past
        // the top of the 32-bit range.
        configure(16'hFFFF, 16'd20);
        record_at(32'hFFFF_FF00);
        record_at(32'hFFFF_FFFF);
        record_at(32'h0000_0040);
        record_at(32'h0000_F000);
        send_beat(ACT_MEASURE, 32'h0000_F010);
        send_beat(ACT_MEASURE, 32'h0000_0000);

        // Random part over several settings.
        configure(WINDOW_RESET, 16'd0);
        random_phase(20, $urandom(), 1'b0);
        configure(16'hFFFF, 16'd0);
        random_phase(20, 32'hFFFF_FC00, 1'b1);
        configure(16'($urandom_range(100, 3000)), 16'($urandom_range(10, 40)));
        random_phase(20, $urandom(), 1'b0);
        configure(16'd300, 16'hFFFF);
        quiet = 1'b1;
        random_phase(20, $urandom(), 1'b0);

        drain();
        repeat (50) @(negedge i_clk);
        $display("Covered %0d arrival records and %0d measurements over seven settings,",
                 record_count, measured_count);
        $display("including wrapped, repeated and out-of-order timestamps.");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/pajm_pkg.sv
hw/rtl/pajm_ram.sv
hw/rtl/pajm_div.sv
hw/rtl/pajm_ctrl.sv
hw/rtl/pajm_dp.sv
hw/rtl/packet_arrival_jitter_meter.sv
tb/jitter_checker.sv
tb/testbench.sv
